// ----- hdl/priority_task_state_manager_defines.svh -----
// Assertion macros for the priority task state manager
`ifndef PRIORITY_TASK_STATE_MANAGER_DEFINES_SVH
`define PRIORITY_TASK_STATE_MANAGER_DEFINES_SVH

// check that the condition implies the consequence in the same cycle
`define PTSM_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

// check that the condition implies the consequence in the next cycle
`define PTSM_ASSERT_NXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ptsm_pkg.sv -----
// Types, codes and helper functions shared by the task state manager
`default_nettype none
package ptsm_pkg;

  localparam int NumTasks = 16;
  localparam int TaskW    = 4;
  localparam int CntW     = 5;
  localparam int TickW    = 32;
  localparam int StampW   = 32;
  localparam int PrioW    = 8;
  localparam int AddrW    = 5;

  localparam logic [2:0] KIND_INIT  = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_WAIT  = 3'd2;
  localparam logic [2:0] KIND_READY = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;
  localparam logic [2:0] KIND_QUERY = 3'd5;

  localparam logic [1:0] REG_PRIO_LO = 2'd0;
  localparam logic [1:0] REG_PRIO_HI = 2'd1;
  localparam logic [1:0] REG_ENABLE  = 2'd2;

  typedef enum logic [1:0] {
    SET_NONE  = 2'd0,
    SET_READY = 2'd1,
    SET_WAIT  = 2'd2,
    SET_STOP  = 2'd3
  } set_t;

  typedef struct packed {
    set_t              tset;
    logic [TickW-1:0]  ticks;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic [TaskW-1:0]  raddr;
    logic              we;
    logic [TaskW-1:0]  waddr;
    entry_t            wdata;
  } mem_req_t;

  typedef struct packed {
    logic [63:0]         prio_lo;
    logic [63:0]         prio_hi;
    logic [NumTasks-1:0] enable;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_CMD_RD,
    ST_CMD_WR,
    ST_TICK_SCAN,
    ST_TICK_UPD,
    ST_TOP_SCAN,
    ST_OUT
  } state_t;

  function automatic logic [PrioW-1:0] prio_of(input cfg_t c, input logic [TaskW-1:0] t);
    logic [127:0] all;
    all = {c.prio_hi, c.prio_lo};
    return all[{t, 3'b000} +: PrioW];
  endfunction

  function automatic logic goes_before(input logic [PrioW-1:0] pa, input logic [PrioW-1:0] pb,
                                       input logic [StampW-1:0] age_a,
                                       input logic [StampW-1:0] age_b,
                                       input logic [TaskW-1:0] a, input logic [TaskW-1:0] b);
    logic r;
    if (pa != pb) begin
      r = pa < pb;
    end else if (age_a != age_b) begin
      r = age_a > age_b;
    end else begin
      r = a < b;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/priority_task_state_manager.sv -----
// Top level of the priority task state manager
//
//  channel | ports                                   | direction
//  in      | in_valid/in_stall, kind, task_req, ticks | command beat in
//  out     | out_valid/out_stall, status..woken_count | result beat out
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata  | APB registers, 64-bit
//
// Stop, wait and ready do one read-modify-write of the entry; init reads every
// slot and writes each enabled empty one; tick does one scan and an update per
// waiting task plus one final scan; every beat then ends in a ready scan of the
// entry memory, one entry per cycle through its single read port, and then
// presents its result in the output register.
// Reset is synchronous, active low, and clears all entries at once.
// A stalled result holds in the output register; a new beat is taken while it waits.
`default_nettype none
module priority_task_state_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_task_req,
  input  logic [31:0] in_wait_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic        out_top_valid,
  output logic [3:0]  out_top_task,
  output logic [1:0]  out_task_set,
  output logic [31:0] out_task_ticks,
  output logic [4:0]  out_woken_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ptsm_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  entry_t   rd_data;

  ptsm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptsm_entry_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  ptsm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_task_req     (in_task_req),
    .in_wait_ticks   (in_wait_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_top_valid   (out_top_valid),
    .out_top_task    (out_top_task),
    .out_task_set    (out_task_set),
    .out_task_ticks  (out_task_ticks),
    .out_woken_count (out_woken_count),
    .mem_req         (mem_req),
    .rd_data         (rd_data)
  );

endmodule
`default_nettype wire

// ----- hdl/ptsm_cfg.sv -----
// APB register file holding task priorities and the enable mask
`default_nettype none
module ptsm_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output ptsm_pkg::cfg_t       cfg
);
  import ptsm_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;

  assign idx    = paddr[4:3];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_PRIO_LO: cfg_nxt.prio_lo = pwdata;
        REG_PRIO_HI: cfg_nxt.prio_hi = pwdata;
        REG_ENABLE:  cfg_nxt.enable  = pwdata[NumTasks-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRIO_LO: prdata = cfg_r.prio_lo;
      REG_PRIO_HI: prdata = cfg_r.prio_hi;
      REG_ENABLE:  prdata = {{(64-NumTasks){1'b0}}, cfg_r.enable};
      default:     prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ptsm_entry_ram.sv -----
// Task entry memory with per-entry valid bits cleared at reset
`default_nettype none
module ptsm_entry_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  ptsm_pkg::mem_req_t  req,
  output ptsm_pkg::entry_t    rd_data
);
  import ptsm_pkg::*;

  entry_t              mem [NumTasks];
  entry_t              rd_q_r;
  logic                rd_vld_r;
  logic [NumTasks-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r <= vld_r[req.raddr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

// ----- hdl/ptsm_ctrl.sv -----
// Command sequencer: read-modify-write of task entries and ordered scans
`default_nettype none
`include "priority_task_state_manager_defines.svh"
module ptsm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptsm_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_kind,
  input  logic [3:0]            in_task_req,
  input  logic [31:0]           in_wait_ticks,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_status,
  output logic                  out_top_valid,
  output logic [3:0]            out_top_task,
  output logic [1:0]            out_task_set,
  output logic [31:0]           out_task_ticks,
  output logic [4:0]            out_woken_count,
  output ptsm_pkg::mem_req_t    mem_req,
  input  ptsm_pkg::entry_t      rd_data
);
  import ptsm_pkg::*;

  state_t              state_r, state_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic [TaskW-1:0]    req_r, req_nxt;
  logic [TickW-1:0]    wticks_r, wticks_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [TaskW-1:0]    pend_addr_r, pend_addr_nxt;
  logic [StampW-1:0]   stamp_ctr_r, stamp_ctr_nxt;
  logic                status_r, status_nxt;
  logic [CntW-1:0]     woken_r, woken_nxt;
  logic [NumTasks-1:0] seen_r, seen_nxt;
  logic                best_vld_r, best_vld_nxt;
  logic [TaskW-1:0]    best_idx_r, best_idx_nxt;
  logic [StampW-1:0]   best_stamp_r, best_stamp_nxt;
  logic [TickW-1:0]    best_ticks_r, best_ticks_nxt;
  set_t                req_set_r, req_set_nxt;
  logic [TickW-1:0]    req_ticks_r, req_ticks_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                o_status_r, o_status_nxt;
  logic                o_top_valid_r, o_top_valid_nxt;
  logic [TaskW-1:0]    o_top_task_r, o_top_task_nxt;
  logic [1:0]          o_task_set_r, o_task_set_nxt;
  logic [TickW-1:0]    o_task_ticks_r, o_task_ticks_nxt;
  logic [CntW-1:0]     o_woken_r, o_woken_nxt;

  logic                in_acc;
  logic                scan_done;
  logic                out_free;
  logic                better;
  logic [TickW-1:0]    dec_ticks;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign scan_done = cnt_r[CntW-1] && !pend_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign dec_ticks = best_ticks_r - 32'd1;
  assign better    = !best_vld_r ||
                     goes_before(prio_of(cfg, pend_addr_r), prio_of(cfg, best_idx_r),
                                 stamp_ctr_r - rd_data.stamp, stamp_ctr_r - best_stamp_r,
                                 pend_addr_r, best_idx_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_INIT:  state_nxt = ST_INIT_RD;
            KIND_STOP:  state_nxt = ST_CMD_RD;
            KIND_WAIT:  state_nxt = ST_CMD_RD;
            KIND_READY: state_nxt = ST_CMD_RD;
            KIND_TICK:  state_nxt = ST_TICK_SCAN;
            default:    state_nxt = ST_TOP_SCAN;
          endcase
        end
      end
      ST_INIT_RD:   state_nxt = ST_INIT_WR;
      ST_INIT_WR:   state_nxt = (cnt_r[TaskW-1:0] == '0) ? ST_TOP_SCAN : ST_INIT_RD;
      ST_CMD_RD:    state_nxt = ST_CMD_WR;
      ST_CMD_WR:    state_nxt = ST_TOP_SCAN;
      ST_TICK_SCAN: begin
        if (scan_done) begin
          state_nxt = best_vld_r ? ST_TICK_UPD : ST_TOP_SCAN;
        end
      end
      ST_TICK_UPD:  state_nxt = ST_TICK_SCAN;
      ST_TOP_SCAN:  state_nxt = scan_done ? ST_OUT : ST_TOP_SCAN;
      ST_OUT:       state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt         = kind_r;
    req_nxt          = req_r;
    wticks_nxt       = wticks_r;
    cnt_nxt          = cnt_r;
    pend_nxt         = 1'b0;
    pend_addr_nxt    = cnt_r[TaskW-1:0];
    stamp_ctr_nxt    = stamp_ctr_r;
    status_nxt       = status_r;
    woken_nxt        = woken_r;
    seen_nxt         = seen_r;
    best_vld_nxt     = best_vld_r;
    best_idx_nxt     = best_idx_r;
    best_stamp_nxt   = best_stamp_r;
    best_ticks_nxt   = best_ticks_r;
    req_set_nxt      = req_set_r;
    req_ticks_nxt    = req_ticks_r;
    out_valid_nxt    = out_valid_r && out_stall;
    o_status_nxt     = o_status_r;
    o_top_valid_nxt  = o_top_valid_r;
    o_top_task_nxt   = o_top_task_r;
    o_task_set_nxt   = o_task_set_r;
    o_task_ticks_nxt = o_task_ticks_r;
    o_woken_nxt      = o_woken_r;
    mem_req          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt     = in_kind;
          req_nxt      = in_task_req;
          wticks_nxt   = in_wait_ticks;
          status_nxt   = 1'b0;
          woken_nxt    = '0;
          seen_nxt     = '0;
          best_vld_nxt = 1'b0;
          best_idx_nxt = '0;
          cnt_nxt      = (in_kind == KIND_INIT) ? CntW'(NumTasks - 1) : '0;
        end
      end
      ST_INIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt_r[TaskW-1:0];
      end
      ST_INIT_WR: begin
        if (cfg.enable[cnt_r[TaskW-1:0]] && rd_data.tset == SET_NONE) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = cnt_r[TaskW-1:0];
          mem_req.wdata.tset  = SET_READY;
          mem_req.wdata.ticks = rd_data.ticks;
          mem_req.wdata.stamp = stamp_ctr_r;
          stamp_ctr_nxt       = stamp_ctr_r + 32'd1;
        end
        cnt_nxt = (cnt_r[TaskW-1:0] == '0) ? '0 : cnt_r - CntW'(1);
      end
      ST_CMD_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = req_r;
      end
      ST_CMD_WR: begin
        mem_req.waddr = req_r;
        mem_req.wdata = rd_data;
        case (kind_r)
          KIND_STOP: begin
            if (rd_data.tset == SET_READY || rd_data.tset == SET_WAIT) begin
              mem_req.we          = 1'b1;
              mem_req.wdata.tset  = SET_STOP;
              mem_req.wdata.stamp = stamp_ctr_r;
              stamp_ctr_nxt       = stamp_ctr_r + 32'd1;
            end else begin
              status_nxt = 1'b1;
            end
          end
          KIND_WAIT: begin
            mem_req.we          = 1'b1;
            mem_req.wdata.ticks = wticks_r;
            if (rd_data.tset == SET_READY) begin
              mem_req.wdata.tset  = SET_WAIT;
              mem_req.wdata.stamp = stamp_ctr_r;
              stamp_ctr_nxt       = stamp_ctr_r + 32'd1;
            end else begin
              status_nxt = 1'b1;
            end
          end
          KIND_READY: begin
            if (rd_data.tset == SET_WAIT || rd_data.tset == SET_STOP) begin
              mem_req.we          = 1'b1;
              mem_req.wdata.tset  = SET_READY;
              mem_req.wdata.stamp = stamp_ctr_r;
              stamp_ctr_nxt       = stamp_ctr_r + 32'd1;
            end else begin
              status_nxt = 1'b1;
            end
          end
          default: status_nxt = status_r;
        endcase
      end
      ST_TICK_SCAN, ST_TOP_SCAN: begin
        if (!cnt_r[CntW-1]) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_r[TaskW-1:0];
          pend_nxt      = 1'b1;
          cnt_nxt       = cnt_r + CntW'(1);
        end
        if (pend_r) begin
          if (state_r == ST_TOP_SCAN && pend_addr_r == req_r) begin
            req_set_nxt   = rd_data.tset;
            req_ticks_nxt = rd_data.ticks;
          end
          if (((state_r == ST_TICK_SCAN && rd_data.tset == SET_WAIT &&
                !seen_r[pend_addr_r]) ||
               (state_r == ST_TOP_SCAN && rd_data.tset == SET_READY)) && better) begin
            best_vld_nxt   = 1'b1;
            best_idx_nxt   = pend_addr_r;
            best_stamp_nxt = rd_data.stamp;
            best_ticks_nxt = rd_data.ticks;
          end
        end
        if (scan_done && state_r == ST_TICK_SCAN && !best_vld_r) begin
          cnt_nxt      = '0;
          best_idx_nxt = '0;
        end
      end
      ST_TICK_UPD: begin
        seen_nxt[best_idx_r] = 1'b1;
        mem_req.waddr        = best_idx_r;
        mem_req.wdata.ticks  = dec_ticks;
        mem_req.wdata.stamp  = best_stamp_r;
        mem_req.wdata.tset   = SET_WAIT;
        if (best_ticks_r != '0) begin
          mem_req.we = 1'b1;
          if (dec_ticks == '0) begin
            mem_req.wdata.tset  = SET_READY;
            mem_req.wdata.stamp = stamp_ctr_r;
            stamp_ctr_nxt       = stamp_ctr_r + 32'd1;
            woken_nxt           = woken_r + CntW'(1);
          end
        end
        cnt_nxt      = '0;
        best_vld_nxt = 1'b0;
        best_idx_nxt = '0;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          o_status_nxt     = status_r;
          o_top_valid_nxt  = best_vld_r;
          o_top_task_nxt   = best_vld_r ? best_idx_r : '0;
          o_task_set_nxt   = req_set_r;
          o_task_ticks_nxt = req_ticks_r;
          o_woken_nxt      = woken_r;
        end
      end
      default: mem_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      stamp_ctr_r <= '0;
      out_valid_r <= 1'b0;
      best_vld_r  <= 1'b0;
      seen_r      <= '0;
      woken_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      stamp_ctr_r <= stamp_ctr_nxt;
      out_valid_r <= out_valid_nxt;
      best_vld_r  <= best_vld_nxt;
      seen_r      <= seen_nxt;
      woken_r     <= woken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r         <= kind_nxt;
    req_r          <= req_nxt;
    wticks_r       <= wticks_nxt;
    pend_addr_r    <= pend_addr_nxt;
    status_r       <= status_nxt;
    best_idx_r     <= best_idx_nxt;
    best_stamp_r   <= best_stamp_nxt;
    best_ticks_r   <= best_ticks_nxt;
    req_set_r      <= req_set_nxt;
    req_ticks_r    <= req_ticks_nxt;
    o_status_r     <= o_status_nxt;
    o_top_valid_r  <= o_top_valid_nxt;
    o_top_task_r   <= o_top_task_nxt;
    o_task_set_r   <= o_task_set_nxt;
    o_task_ticks_r <= o_task_ticks_nxt;
    o_woken_r      <= o_woken_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_top_valid   = o_top_valid_r;
  assign out_top_task    = o_top_task_r;
  assign out_task_set    = o_task_set_r;
  assign out_task_ticks  = o_task_ticks_r;
  assign out_woken_count = o_woken_r;

  `PTSM_ASSERT_IMP(a_write_state, clk, rst_n, mem_req.we, (state_r == ST_INIT_WR || state_r == ST_CMD_WR || state_r == ST_TICK_UPD), "entry write outside a write state")
  `PTSM_ASSERT_IMP(a_stamp_with_write, clk, rst_n, (stamp_ctr_nxt != stamp_ctr_r), mem_req.we, "stamp advanced without an entry write")
  `PTSM_ASSERT_IMP(a_scan_bound, clk, rst_n, 1'b1, (cnt_r <= CntW'(NumTasks)), "scan counter out of range")
  `PTSM_ASSERT_IMP(a_woken_bound, clk, rst_n, 1'b1, (woken_r <= CntW'(NumTasks)), "too many tasks woken")
  `PTSM_ASSERT_NXT(a_result_after_out, clk, rst_n, (state_r == ST_OUT && out_free), out_valid_r, "result not presented")

endmodule
`default_nettype wire
